// ----- sv/spectral_flux_analyzer_macros.svh -----
// Assertion macros shared by the spectral flux analyzer checkers.
// Used through `include by the files that hold concurrent assertions.
`ifndef SPECTRAL_FLUX_ANALYZER_MACROS_SVH
`define SPECTRAL_FLUX_ANALYZER_MACROS_SVH

// Same-cycle implication, disabled while reset is high
`define SFA_ASSERT_IMP(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is high
`define SFA_ASSERT_NXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/sfa_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants of the spectral flux analyzer.
// No dependencies; used by the top level and its checker.
package sfa_pkg;

  // Parameter defaults
  localparam int FFT_SIZE_DEF  = 1024;
  localparam int BIN_WIDTH_DEF = 24;

  // Result field widths and packing of the result tdata
  localparam int MAG_W   = 24;
  localparam int ACC_W   = 33;
  localparam int OUT_W   = 96;
  localparam int OUT_PAD = OUT_W - 2 * ACC_W - MAG_W;

  localparam logic [MAG_W-1:0] MAG_MAX = '1;
  localparam logic [ACC_W-1:0] ACC_MAX = '1;

  // Per-bin sequencer
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_START,
    ST_ROOT,
    ST_UPDATE
  } sfa_state_t;

endpackage

// ----- sv/sfa_ram.sv -----
`timescale 1ns / 1ps
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module sfa_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- sv/sfa_sqrt.sv -----
`timescale 1ns / 1ps
// Bit-serial integer square root: one root bit per cycle.
// No dependencies.
module sfa_sqrt #(
  parameter int W = 24
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [2*W-1:0] radicand,
  output logic           done,
  output logic [W-1:0]   root
);

  localparam int CW = $clog2(W);

  logic [2*W-1:0] rad;
  logic [W+1:0]   rem;
  logic [CW-1:0]  cnt;
  logic           active;

  logic [W+1:0]   rem_shift;
  logic [W+1:0]   trial;
  logic           take;

  // One restoring step: bring down two radicand bits, try root*4+1
  always_comb begin
    rem_shift = {rem[W-1:0], rad[2*W-1:2*W-2]};
    trial     = {root, 2'b01};
    take      = (rem_shift >= trial);
  end

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      cnt    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active <= 1'b1;
        cnt    <= '0;
      end else if (active) begin
        if (cnt == CW'(W - 1)) begin
          active <= 1'b0;
          done   <= 1'b1;
        end else begin
          cnt <= cnt + 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rad  <= radicand;
      rem  <= '0;
      root <= '0;
    end else if (active) begin
      rad  <= {rad[2*W-3:0], 2'b00};
      rem  <= take ? (rem_shift - trial) : rem_shift;
      root <= {root[W-2:0], take};
    end
  end

endmodule

// ----- sv/spectral_flux_analyzer.sv -----
`timescale 1ns / 1ps
// Spectral flux analyzer top level: bin magnitude, frame statistics, flux.
// Depends on sfa_pkg, sfa_ram and sfa_sqrt.
//
// Each input transfer carries one complex FFT bin; s_tlast marks the last bin
// of a frame. The magnitude floor(sqrt(re^2 + im^2)) is found by a bit-serial
// root, so the block works on one bin at a time and s_tready is high only
// between bins. The previous frame's magnitudes live in a RAM of FFT_SIZE/2
// entries; each bin reads its entry before the root starts and writes the new
// magnitude at the end, so reads and writes of one entry never overlap. The
// RAM needs no clearing pass: the first frame after reset only stores, and
// reports flux 0 with first_frame set. On the last bin one result is loaded
// into the output register (flux, peak, magnitude sum, each sum saturating at
// 2^33-1); a result still waiting on m_tready holds the final step of the
// next last bin until it is taken.
module spectral_flux_analyzer #(
  parameter int FFT_SIZE  = sfa_pkg::FFT_SIZE_DEF,
  parameter int BIN_WIDTH = sfa_pkg::BIN_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // Input bins
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // s_tdata: bin_real, bin_imag (from bit 0), zero padded to bytes
  input  logic [((2*BIN_WIDTH+7)/8)*8-1:0]    s_tdata,
  input  logic                                s_tlast,   // last_bin
  // Frame results
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // m_tdata: spectral_flux, peak_magnitude, magnitude_sum (from bit 0)
  output logic [sfa_pkg::OUT_W-1:0]           m_tdata,
  output logic                                m_tuser    // first_frame
);

  import sfa_pkg::*;

  localparam int SPEC_DEPTH = FFT_SIZE / 2;
  localparam int PW         = $clog2(SPEC_DEPTH);
  localparam int SQ_W       = 2 * BIN_WIDTH;
  localparam int RW         = (BIN_WIDTH > MAG_W) ? BIN_WIDTH : MAG_W;

  sfa_state_t state, state_next;

  logic [BIN_WIDTH-1:0] s_re, s_im;
  logic [BIN_WIDTH-1:0] re_abs, im_abs;
  logic [BIN_WIDTH-1:0] abs_re, abs_im;
  logic                 last_q;
  logic [SQ_W-1:0]      sq_re, sq_im;
  logic                 sq_start;
  logic                 root_done;
  logic [BIN_WIDTH-1:0] root;
  logic [RW-1:0]        root_ext;
  logic [MAG_W-1:0]     mag;

  logic [PW-1:0]        pos;
  logic                 have_prev;
  logic [ACC_W-1:0]     flux_acc, sum_acc;
  logic [MAG_W-1:0]     peak_acc;
  logic [MAG_W-1:0]     old_mag;
  logic                 rd_en;
  logic                 upd_go;
  logic                 out_load;

  logic [MAG_W-1:0]     diff;
  logic [ACC_W:0]       flux_sum, mag_sum;
  logic [ACC_W-1:0]     flux_next, sum_next;
  logic [MAG_W-1:0]     peak_next;

  logic [ACC_W-1:0]     out_flux, out_sum;
  logic [MAG_W-1:0]     out_peak;
  logic                 out_first;

  // Unpack and take absolute values of the input fields
  always_comb begin
    s_re   = s_tdata[BIN_WIDTH-1:0];
    s_im   = s_tdata[2*BIN_WIDTH-1:BIN_WIDTH];
    re_abs = s_re[BIN_WIDTH-1] ? (~s_re + 1'b1) : s_re;
    im_abs = s_im[BIN_WIDTH-1] ? (~s_im + 1'b1) : s_im;
  end

  // Sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and step strobes
  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    sq_start   = 1'b0;
    rd_en      = 1'b0;
    upd_go     = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          state_next = ST_SQUARE;
        end
      end
      ST_SQUARE: begin
        state_next = ST_START;
      end
      ST_START: begin
        sq_start   = 1'b1;
        rd_en      = 1'b1;
        state_next = ST_ROOT;
      end
      ST_ROOT: begin
        if (root_done) begin
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (!last_q || !m_tvalid || m_tready) begin
          upd_go     = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign out_load = upd_go && last_q;

  // Capture the bin and square its parts
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      abs_re <= re_abs;
      abs_im <= im_abs;
      last_q <= s_tlast;
    end
    if (state == ST_SQUARE) begin
      sq_re <= SQ_W'(abs_re) * SQ_W'(abs_re);
      sq_im <= SQ_W'(abs_im) * SQ_W'(abs_im);
    end
  end

  sfa_sqrt #(
    .W (BIN_WIDTH)
  ) u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sq_start),
    .radicand (sq_re + sq_im),
    .done     (root_done),
    .root     (root)
  );

  // Saturate the root to the magnitude width
  assign root_ext = RW'(root);

  always_ff @(posedge clk) begin
    if (state == ST_ROOT && root_done) begin
      mag <= (root_ext > RW'(MAG_MAX)) ? MAG_MAX : MAG_W'(root_ext);
    end
  end

  // Previous spectrum: read at START, written back at UPDATE
  sfa_ram #(
    .WIDTH (MAG_W),
    .DEPTH (SPEC_DEPTH)
  ) u_spec_ram (
    .clk     (clk),
    .wr_en   (upd_go),
    .wr_addr (pos),
    .wr_data (mag),
    .rd_en   (rd_en),
    .rd_addr (pos),
    .rd_data (old_mag)
  );

  // Accumulator updates with saturation
  always_comb begin
    diff      = (have_prev && mag > old_mag) ? (mag - old_mag) : '0;
    flux_sum  = {1'b0, flux_acc} + (ACC_W + 1)'(diff);
    mag_sum   = {1'b0, sum_acc} + (ACC_W + 1)'(mag);
    flux_next = flux_sum[ACC_W] ? ACC_MAX : flux_sum[ACC_W-1:0];
    sum_next  = mag_sum[ACC_W] ? ACC_MAX : mag_sum[ACC_W-1:0];
    peak_next = (mag > peak_acc) ? mag : peak_acc;
  end

  // Frame state
  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= '0;
      have_prev <= 1'b0;
      flux_acc  <= '0;
      sum_acc   <= '0;
      peak_acc  <= '0;
    end else if (upd_go) begin
      if (last_q) begin
        pos       <= '0;
        have_prev <= 1'b1;
        flux_acc  <= '0;
        sum_acc   <= '0;
        peak_acc  <= '0;
      end else begin
        pos      <= (pos == PW'(SPEC_DEPTH - 1)) ? '0 : pos + 1'b1;
        flux_acc <= flux_next;
        sum_acc  <= sum_next;
        peak_acc <= peak_next;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_flux  <= have_prev ? flux_next : '0;
      out_peak  <= peak_next;
      out_sum   <= sum_next;
      out_first <= !have_prev;
    end
  end

  assign m_tdata = {{OUT_PAD{1'b0}}, out_sum, out_peak, out_flux};
  assign m_tuser = out_first;

endmodule

// ----- sv/sfa_checker.sv -----
`timescale 1ns / 1ps
// Port-level checker for the spectral flux analyzer, bound to the top level.
// Depends on sfa_pkg and spectral_flux_analyzer_macros.svh.
`include "spectral_flux_analyzer_macros.svh"

module sfa_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        s_tvalid,
  input logic                        s_tready,
  input logic                        m_tvalid,
  input logic                        m_tready,
  input logic [sfa_pkg::OUT_W-1:0]   m_tdata,
  input logic                        m_tuser
);

  import sfa_pkg::*;

  // A stalled result keeps its payload
  `SFA_ASSERT_NXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

  // One bin at a time: the block is busy right after a transfer
  `SFA_ASSERT_NXT(a_busy_after_in, clk, rst, s_tvalid && s_tready, !s_tready, "input taken while a bin is in work")

  // First frame reports no flux
  `SFA_ASSERT_IMP(a_first_no_flux, clk, rst, m_tvalid && m_tuser, m_tdata[ACC_W-1:0] == '0, "flux on first frame")

  // The peak never exceeds the magnitude sum
  `SFA_ASSERT_IMP(a_peak_le_sum, clk, rst, m_tvalid, m_tdata[ACC_W+MAG_W-1:ACC_W] <= m_tdata[2*ACC_W+MAG_W-1:ACC_W+MAG_W], "peak above sum")

endmodule

bind spectral_flux_analyzer sfa_checker u_sfa_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking bench for spectral_flux_analyzer: bins in, per-frame flux stats out.
// Depends on sfa_pkg and the spectral_flux_analyzer top level, which brings in sfa_ram and sfa_sqrt.
module tb_top;
  import sfa_pkg::*;

  localparam int BW          = BIN_WIDTH_DEF;
  localparam int S_W         = ((2 * BW + 7) / 8) * 8;
  localparam int SPEC_DEPTH  = FFT_SIZE_DEF / 2;
  localparam int FIRST_FRAME_LEN = SPEC_DEPTH + 24;
  localparam int PHASE_ITEMS = 65;
  localparam int HOLD_CYCLES = 600;
  localparam int DRAIN_CYCLES = 64;
  localparam longint CYCLE_LIMIT = 1_500_000;
  localparam int TX_IDLE [4]  = '{0, 56, 0, 29};
  localparam int RX_STALL [4] = '{0, 0, 56, 29};

  typedef struct packed {
    logic [ACC_W-1:0] flux;
    logic [MAG_W-1:0] peak;
    logic [ACC_W-1:0] total;
    logic             first;
  } frame_stats_t;

  // Frame statistics predictor and result checker
  class flux_scoreboard;
    logic [MAG_W-1:0] stored_mag [SPEC_DEPTH];
    bit               have_prev;
    int               bin_idx;
    logic [ACC_W-1:0] flux_acc;
    logic [ACC_W-1:0] sum_acc;
    logic [MAG_W-1:0] peak_acc;
    frame_stats_t     expected_q [$];
    int errors, bins_seen, frames_checked, frame_len, longest_frame;

    function new();
      foreach (stored_mag[i]) stored_mag[i] = '0;
      have_prev = 0;
      bin_idx = 0;
      flux_acc = '0;
      sum_acc = '0;
      peak_acc = '0;
      errors = 0;
      bins_seen = 0;
      frames_checked = 0;
      frame_len = 0;
      longest_frame = 0;
    endfunction

    // floor(sqrt(re^2 + im^2)), found one result bit at a time from the top
    function logic [MAG_W-1:0] bin_magnitude(logic [BW-1:0] re, logic [BW-1:0] im);
      logic [BW-1:0]   re_abs, im_abs;
      logic [2*BW-1:0] power;
      longint unsigned root, cand;
      re_abs = re[BW-1] ? -re : re;
      im_abs = im[BW-1] ? -im : im;
      power = re_abs * re_abs + im_abs * im_abs;
      root = 0;
      for (int b = BW; b >= 0; b--) begin
        cand = root | (64'd1 << b);
        if (cand * cand <= power) root = cand;
      end
      if (root > MAG_MAX) return MAG_MAX;
      return MAG_W'(root);
    endfunction

    function logic [ACC_W-1:0] acc_add(logic [ACC_W-1:0] a, logic [MAG_W-1:0] b);
      logic [ACC_W:0] s;
      s = a + b;
      return s[ACC_W] ? ACC_MAX : s[ACC_W-1:0];
    endfunction

    // One accepted bin: read-modify-write of the stored spectrum, update sums
    function void note_bin(logic [BW-1:0] re, logic [BW-1:0] im, logic frame_end);
      logic [MAG_W-1:0] mag, old;
      frame_stats_t     want;
      mag = bin_magnitude(re, im);
      old = stored_mag[bin_idx];
      if (have_prev && mag > old) flux_acc = acc_add(flux_acc, mag - old);
      stored_mag[bin_idx] = mag;
      sum_acc = acc_add(sum_acc, mag);
      if (mag > peak_acc) peak_acc = mag;
      bin_idx = (bin_idx + 1) % SPEC_DEPTH;
      bins_seen++;
      frame_len++;
      if (frame_end) begin
        want.flux  = have_prev ? flux_acc : '0;
        want.peak  = peak_acc;
        want.total = sum_acc;
        want.first = !have_prev;
        expected_q = {expected_q, want};
        if (frame_len > longest_frame) longest_frame = frame_len;
        have_prev = 1;
        bin_idx = 0;
        flux_acc = '0;
        sum_acc = '0;
        peak_acc = '0;
        frame_len = 0;
      end
    endfunction

    task report_mismatch(string msg);
      $display("MISMATCH @%0t: %s", $time, msg);
      errors++;
    endtask

    // Compare one result transfer against the oldest pending frame
    task check_result(frame_stats_t got);
      frame_stats_t want;
      string        diffs;
      if (expected_q.size() == 0) begin
        report_mismatch("frame result with no frame pending");
        return;
      end
      want = expected_q.pop_front();
      diffs = "";
      if (got.flux !== want.flux)
        diffs = {diffs, $sformatf(" flux got %0d want %0d", got.flux, want.flux)};
      if (got.peak !== want.peak)
        diffs = {diffs, $sformatf(" peak got %0d want %0d", got.peak, want.peak)};
      if (got.total !== want.total)
        diffs = {diffs, $sformatf(" sum got %0d want %0d", got.total, want.total)};
      if (got.first !== want.first)
        diffs = {diffs, $sformatf(" first got %b want %b", got.first, want.first)};
      if (diffs != "") report_mismatch($sformatf("frame %0d:%s", frames_checked, diffs));
      frames_checked++;
    endtask
  endclass

  logic             clk;
  logic             rst;
  logic             s_tvalid;
  logic             s_tready;
  logic [S_W-1:0]   s_tdata;
  logic             s_tlast;
  logic             m_tvalid;
  logic             m_tready;
  logic [OUT_W-1:0] m_tdata;
  logic             m_tuser;

  int     tx_idle_pct = 0;
  int     rx_stall_pct = 0;
  bit     hold_pending = 0;
  longint cycle_count = 0;

  flux_scoreboard sb = new();

  spectral_flux_analyzer dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Observe both streams at each edge
  always @(posedge clk) begin
    frame_stats_t got;
    cycle_count <= cycle_count + 1;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got.flux  = m_tdata[0 +: ACC_W];
        got.peak  = m_tdata[ACC_W +: MAG_W];
        got.total = m_tdata[ACC_W + MAG_W +: ACC_W];
        got.first = m_tuser;
        sb.check_result(got);
      end
      if (s_tvalid && s_tready)
        sb.note_bin(s_tdata[0 +: BW], s_tdata[BW +: BW], s_tlast);
    end
  end

  // Result receiver: random stalls, plus a long hold-off on request
  initial begin : receiver
    int stall_left;
    stall_left = 0;
    m_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_pending) begin
        hold_pending = 1'b0;
        stall_left = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  initial begin : watchdog
    wait (cycle_count >= CYCLE_LIMIT);
    $display("end of test: mismatches");
    $finish;
  end

  // Mostly full-range values, some near zero, some at the signed extremes
  function automatic logic [BW-1:0] pick_component();
    case ($urandom_range(9))
      0, 1, 2, 3, 4: return BW'($urandom());
      5, 6, 7:       return BW'(int'($urandom_range(0, 31)) - 16);
      8:             return {1'b1, {(BW-1){1'b0}}};
      default:       return {1'b0, {(BW-1){1'b1}}};
    endcase
  endfunction

  // Mostly short frames; now and then a longer one
  function automatic int pick_frame_len();
    int r;
    r = $urandom_range(99);
    if (r < 75) return $urandom_range(1, 6);
    if (r < 97) return $urandom_range(7, 40);
    return $urandom_range(41, 96);
  endfunction

  // One bin transfer, after an optional idle gap on the input
  task automatic send_bin(logic [BW-1:0] re, logic [BW-1:0] im, logic frame_end);
    int gap;
    gap = 0;
    if ($urandom_range(99) < tx_idle_pct) gap = $urandom_range(1, 35);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= S_W'({im, re});
    s_tlast  <= frame_end;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic send_frame(int len);
    for (int i = 0; i < len; i++)
      send_bin(pick_component(), pick_component(), i == len - 1);
  endtask

  initial begin : stimulus
    int phase_items;
    int len;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tlast = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // First frame runs past the spectrum depth: every entry gets written,
    // and the bin position wraps onto entries already rewritten
    send_bin({1'b1, {(BW-1){1'b0}}}, {1'b1, {(BW-1){1'b0}}}, 1'b0);
    for (int i = 1; i < FIRST_FRAME_LEN; i++)
      send_bin(pick_component(), pick_component(), i == FIRST_FRAME_LEN - 1);

    // Directed corners: largest magnitude, zero, one-sided extremes, small values
    send_bin({1'b1, {(BW-1){1'b0}}}, {1'b1, {(BW-1){1'b0}}}, 1'b1);
    send_bin('0, '0, 1'b1);
    send_bin({1'b0, {(BW-1){1'b1}}}, '0, 1'b0);
    send_bin('0, {1'b1, {(BW-1){1'b0}}}, 1'b1);
    send_bin('1, BW'(1), 1'b0);
    send_bin(BW'(3), BW'(-4), 1'b0);
    send_bin({1'b1, {(BW-1){1'b0}}}, {1'b0, {(BW-1){1'b1}}}, 1'b1);
    send_bin({1'b0, {(BW-1){1'b1}}}, {1'b0, {(BW-1){1'b1}}}, 1'b1);

    // Random frames under each idling mix
    for (int p = 0; p < 4; p++) begin
      tx_idle_pct = TX_IDLE[p];
      rx_stall_pct = RX_STALL[p];
      phase_items = 0;
      if (p == 0) begin
        // hold results back while one-bin frames keep coming
        hold_pending = 1'b1;
        for (int k = 0; k < 40; k++) send_frame(1);
        phase_items = 40;
      end
      while (phase_items < PHASE_ITEMS) begin
        len = pick_frame_len();
        send_frame(len);
        phase_items += len;
      end
    end
    s_tvalid <= 1'b0;

    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d bins over %0d frames; longest frame %0d bins (spectrum depth %0d).",
             sb.bins_seen, sb.frames_checked, sb.longest_frame, SPEC_DEPTH);
    $display("Idle mixes on both sides and a long result hold-off; mismatches counted: %0d.",
             sb.errors);
    if (sb.errors == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule

// ----- spectral_flux_analyzer.f -----
+incdir+sv
sv/sfa_pkg.sv
sv/sfa_ram.sv
sv/sfa_sqrt.sv
sv/spectral_flux_analyzer.sv
sv/sfa_checker.sv
bench/tb_top.sv
